>>> rtl/ppoe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppoe_pkg: shared types and constants of the pilot phase offset estimator
// Payload structs of both channels, register map and the CORDIC angle table.
// ----------------------------------------------------------------------------
package ppoe_pkg;

  localparam int ACC_W        = 40;
  localparam int DER_W        = 18;
  localparam int GAIN_W       = 32;
  localparam int PROD_W       = DER_W + GAIN_W;
  localparam int VEC_W        = 42;
  localparam int ITER_W       = 4;
  localparam int CORDIC_ITERS = 15;
  localparam int ADDR_W       = 4;
  localparam int DATA_W       = 32;

  localparam logic [GAIN_W-1:0] FREQ_GAIN_RESET  = 32'd0;
  localparam logic [GAIN_W-1:0] SAMP_GAIN_RESET  = 32'd0;
  localparam logic [GAIN_W-1:0] SLOPE_GAIN_RESET = 32'd2796203;

  localparam logic signed [19:0] SLOPE_LIMIT = 20'sd524287;
  localparam logic [15:0]        ANGLE_PI    = 16'h8000;

  typedef enum logic [1:0] {
    REG_FREQ_GAIN  = 2'd0,
    REG_SAMP_GAIN  = 2'd1,
    REG_SLOPE_GAIN = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] first_re;
    logic signed [15:0] first_im;
    logic               first_ref_re_neg;
    logic               first_ref_im_neg;
    logic signed [15:0] second_re;
    logic signed [15:0] second_im;
    logic               second_ref_re_neg;
    logic               second_ref_im_neg;
    logic               last;
  } pilot_t;

  typedef struct packed {
    logic signed [15:0] phase_angle;
    logic signed [31:0] frequency_step;
    logic signed [31:0] sampling_step;
    logic signed [19:0] slope_correction;
    logic               slope_clamped;
  } estimate_t;

  // round(atan(2^-i) * 32768 / pi)
  function automatic logic [15:0] atan_step(input logic [ITER_W-1:0] i);
    logic [15:0] v;
    unique case (i)
      4'd0:    v = 16'd8192;
      4'd1:    v = 16'd4836;
      4'd2:    v = 16'd2555;
      4'd3:    v = 16'd1297;
      4'd4:    v = 16'd651;
      4'd5:    v = 16'd326;
      4'd6:    v = 16'd163;
      4'd7:    v = 16'd81;
      4'd8:    v = 16'd41;
      4'd9:    v = 16'd20;
      4'd10:   v = 16'd10;
      4'd11:   v = 16'd5;
      4'd12:   v = 16'd3;
      4'd13:   v = 16'd1;
      4'd14:   v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/ppoe_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppoe_if: valid/ready channels of the pilot phase offset estimator
// One interface for the pilot pair requests and one for the estimates.
// ----------------------------------------------------------------------------
interface ppoe_in_if;
  import ppoe_pkg::*;
  logic   valid;
  logic   ready;
  pilot_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ppoe_out_if;
  import ppoe_pkg::*;
  logic      valid;
  logic      ready;
  estimate_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/pilot_phase_offset_estimator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pilot_phase_offset_estimator_top: data-aided pilot phase offset estimator
// Correlates derotated pilot pairs and turns the angle into three corrections.
// ----------------------------------------------------------------------------
// Usage: each request on pilots carries two pilot samples with their reference
// signs. The pair is derotated and second * conj(first) is added to 40-bit
// accumulators. A request with last set also produces one request on estimate:
// the correlation angle (pi/32768 units), frequency and sampling steps and the
// clamped slope correction; the accumulators then clear.
// Timing: all arithmetic runs on one 18x32 multiplier and one CORDIC stage
// under a sequencer. A pair without last runs four multiplies plus pipeline
// before the next pair can be accepted. A pair with last runs the correlation,
// setup, 15 CORDIC iterations and the gain steps before the estimate is valid,
// and skips the CORDIC when both accumulators are zero.
// Stalls: the estimate sits in an output register, so new pairs are accepted
// while it waits. A further last pair holds before its gain step until the
// earlier estimate is taken.
// Reset: rst clears accumulators, sequencer and output valid and loads default
// gains. The user writes the gains over the APB port (0x0 frequency, 0x4
// sampling, 0x8 slope) only while the block is idle, not enforced by the block.
// ----------------------------------------------------------------------------
module pilot_phase_offset_estimator_top (
  input  logic                         clk,
  input  logic                         rst,
  ppoe_in_if.sink                      pilots,
  ppoe_out_if.source                   estimate,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ppoe_pkg::ADDR_W-1:0]  paddr,
  input  logic [ppoe_pkg::DATA_W-1:0]  pwdata,
  output logic [ppoe_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import ppoe_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CORR,
    S_VEC_INIT,
    S_VEC,
    S_GAIN
  } state_t;

  state_t state;
  logic [2:0] step;
  logic [ITER_W-1:0] iter;

  logic signed [DER_W-1:0] d0r, d0i, d1r, d1i;
  logic last_q;
  logic [ACC_W-1:0] acc_re, acc_im;
  logic signed [VEC_W-1:0] x, y;
  logic [15:0] z;
  logic signed [PROD_W-1:0] prod;

  logic [GAIN_W-1:0] freq_gain, samp_gain, slope_gain;
  estimate_t out_data;
  logic out_valid;

  logic signed [DER_W-1:0] mul_a;
  logic signed [GAIN_W-1:0] mul_b;
  logic signed [DER_W-1:0] n0r, n0i, n1r, n1i;
  logic signed [VEC_W-1:0] xs, ys, x_ext, y_ext;
  logic signed [PROD_W-17:0] gain_q, gain_neg;
  logic [GAIN_W-1:0] gain_sat;
  logic out_free;
  logic cfg_write;
  reg_idx_t cfg_idx;

  function automatic logic signed [DER_W-1:0] cond_neg(input logic signed [15:0] v,
                                                       input logic n);
    logic signed [DER_W-1:0] e;
    e = DER_W'(v);
    return n ? -e : e;
  endfunction

  // Derotation by the conjugate of a +/-1 +/-1j reference is sign flips and adds.
  assign n0r = cond_neg(pilots.data.first_re, pilots.data.first_ref_re_neg)
             + cond_neg(pilots.data.first_im, pilots.data.first_ref_im_neg);
  assign n0i = cond_neg(pilots.data.first_im, pilots.data.first_ref_re_neg)
             - cond_neg(pilots.data.first_re, pilots.data.first_ref_im_neg);
  assign n1r = cond_neg(pilots.data.second_re, pilots.data.second_ref_re_neg)
             + cond_neg(pilots.data.second_im, pilots.data.second_ref_im_neg);
  assign n1i = cond_neg(pilots.data.second_im, pilots.data.second_ref_re_neg)
             - cond_neg(pilots.data.second_re, pilots.data.second_ref_im_neg);

  assign pilots.ready   = (state == S_IDLE);
  assign estimate.valid = out_valid;
  assign estimate.data  = out_data;
  assign out_free       = !out_valid || estimate.ready;

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == S_CORR) begin
      case (step)
        3'd0: begin mul_a = d1r; mul_b = GAIN_W'(d0r); end
        3'd1: begin mul_a = d1i; mul_b = GAIN_W'(d0i); end
        3'd2: begin mul_a = d1i; mul_b = GAIN_W'(d0r); end
        3'd3: begin mul_a = d1r; mul_b = GAIN_W'(d0i); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state == S_GAIN) begin
      mul_a = DER_W'(signed'(z));
      case (step)
        3'd0:    mul_b = signed'(freq_gain);
        3'd1:    mul_b = signed'(samp_gain);
        3'd2:    mul_b = signed'(slope_gain);
        default: mul_b = '0;
      endcase
    end
  end

  assign gain_q   = prod[PROD_W-1:16];
  assign gain_neg = -gain_q;
  always_comb begin
    if (gain_q[PROD_W-17:31] != {(PROD_W-47){gain_q[31]}}) begin
      gain_sat = gain_q[PROD_W-17] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      gain_sat = gain_q[31:0];
    end
  end

  assign xs    = x >>> iter;
  assign ys    = y >>> iter;
  assign x_ext = VEC_W'(signed'(acc_re));
  assign y_ext = VEC_W'(signed'(acc_im));

  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      iter      <= '0;
      acc_re    <= '0;
      acc_im    <= '0;
      out_valid <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      if (out_valid && estimate.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pilots.valid) begin
            d0r    <= n0r;
            d0i    <= n0i;
            d1r    <= n1r;
            d1i    <= n1i;
            last_q <= pilots.data.last;
            step   <= '0;
            state  <= S_CORR;
          end
        end
        S_CORR: begin
          step <= step + 3'd1;
          case (step)
            3'd1, 3'd2: acc_re <= acc_re + prod[ACC_W-1:0];
            3'd3:       acc_im <= acc_im + prod[ACC_W-1:0];
            3'd4: begin
              acc_im <= acc_im - prod[ACC_W-1:0];
              state  <= last_q ? S_VEC_INIT : S_IDLE;
            end
            default: ;
          endcase
        end
        S_VEC_INIT: begin
          iter   <= '0;
          step   <= '0;
          acc_re <= '0;
          acc_im <= '0;
          if (acc_re == '0 && acc_im == '0) begin
            z     <= '0;
            state <= S_GAIN;
          end else begin
            // Fold the left half plane onto the right, starting the angle at pi.
            if (acc_re[ACC_W-1]) begin
              x <= -x_ext;
              y <= -y_ext;
              z <= ANGLE_PI;
            end else begin
              x <= x_ext;
              y <= y_ext;
              z <= '0;
            end
            state <= S_VEC;
          end
        end
        S_VEC: begin
          if (!y[VEC_W-1]) begin
            x <= x + ys;
            y <= y - xs;
            z <= z + atan_step(iter);
          end else begin
            x <= x - ys;
            y <= y + xs;
            z <= z - atan_step(iter);
          end
          iter <= iter + ITER_W'(1);
          if (iter == ITER_W'(CORDIC_ITERS - 1)) begin
            step  <= '0;
            state <= S_GAIN;
          end
        end
        S_GAIN: begin
          case (step)
            3'd0: begin
              // Wait here until an earlier estimate has been taken.
              if (out_free) begin
                step <= 3'd1;
              end
            end
            3'd1: begin
              out_data.frequency_step <= gain_sat;
              step <= 3'd2;
            end
            3'd2: begin
              out_data.sampling_step <= gain_sat;
              step <= 3'd3;
            end
            default: begin
              out_data.phase_angle <= z;
              if (gain_q > (PROD_W-16)'(SLOPE_LIMIT)) begin
                out_data.slope_correction <= -SLOPE_LIMIT;
                out_data.slope_clamped    <= 1'b1;
              end else if (gain_q < -(PROD_W-16)'(SLOPE_LIMIT)) begin
                out_data.slope_correction <= SLOPE_LIMIT;
                out_data.slope_clamped    <= 1'b1;
              end else begin
                out_data.slope_correction <= gain_neg[19:0];
                out_data.slope_clamped    <= 1'b0;
              end
              out_valid <= 1'b1;
              state     <= S_IDLE;
            end
          endcase
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      freq_gain  <= FREQ_GAIN_RESET;
      samp_gain  <= SAMP_GAIN_RESET;
      slope_gain <= SLOPE_GAIN_RESET;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_FREQ_GAIN:  freq_gain  <= pwdata;
        REG_SAMP_GAIN:  samp_gain  <= pwdata;
        REG_SLOPE_GAIN: slope_gain <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FREQ_GAIN:  prdata = freq_gain;
      REG_SAMP_GAIN:  prdata = samp_gain;
      REG_SLOPE_GAIN: prdata = slope_gain;
      default:        prdata = '0;
    endcase
  end

  // The accumulators are already clear when a new estimate appears.
  a_acc_cleared: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (acc_re == '0 && acc_im == '0))
    else $error("accumulators not cleared with estimate");

  // A clamp flag always comes with the clamp value.
  a_clamp_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.slope_clamped) |->
      (out_data.slope_correction == SLOPE_LIMIT ||
       out_data.slope_correction == -SLOPE_LIMIT))
    else $error("slope clamp flag without clamp value");

  // Vectoring keeps the x component in the right half plane.
  a_vec_x_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_VEC) |-> !x[VEC_W-1])
    else $error("CORDIC x went negative");

  // An output still waiting is never overwritten by the gain step.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (state == S_GAIN && step != 3'd0) |-> !out_valid)
    else $error("estimate overwritten before it was taken");

endmodule

>>> dv/ppoe_estimate_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppoe_estimate_checker: predicts and checks pilot phase offset estimates
// Watches the pilot, estimate and APB channels, keeps its own correlation
// accumulators and gain copies, and compares each estimate field by field.
// ----------------------------------------------------------------------------
module ppoe_estimate_checker
  import ppoe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              pilot_valid,
  input  logic              pilot_ready,
  input  pilot_t            pilot_data,
  input  logic              est_valid,
  input  logic              est_ready,
  input  estimate_t         est_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                mismatch_count,
  output int                pending_estimates
);

  localparam int ATAN_LUT [CORDIC_ITERS] = '{
    8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1
  };
  localparam longint STEP_MAX  = 2147483647;
  localparam longint STEP_MIN  = -STEP_MAX - 1;
  localparam longint SLOPE_MAX = 524287;

  logic signed [ACC_W-1:0]  corr_re;
  logic signed [ACC_W-1:0]  corr_im;
  logic signed [GAIN_W-1:0] freq_gain;
  logic signed [GAIN_W-1:0] samp_gain;
  logic signed [GAIN_W-1:0] slope_gain;
  estimate_t                expected_estimates[$];
  int                       errors = 0;

  assign mismatch_count = errors;

  // Multiply a sample by the conjugate of its +/-1 +/-1j reference.
  function automatic void derotate(input logic signed [15:0] s_re, input logic signed [15:0] s_im,
                                   input logic re_neg, input logic im_neg,
                                   output longint d_re, output longint d_im);
    longint r_re;
    longint r_im;
    r_re = re_neg ? -1 : 1;
    r_im = im_neg ? -1 : 1;
    d_re = longint'(s_re) * r_re + longint'(s_im) * r_im;
    d_im = longint'(s_im) * r_re - longint'(s_re) * r_im;
  endfunction

  function automatic logic signed [15:0] cordic_angle(input logic signed [ACC_W-1:0] acc_re,
                                                      input logic signed [ACC_W-1:0] acc_im);
    longint      x;
    longint      y;
    longint      xs;
    longint      ys;
    logic [15:0] z;
    if (acc_re == 0 && acc_im == 0) return 16'sd0;
    x = acc_re;
    y = acc_im;
    z = 16'd0;
    // Fold the left half plane onto the right one; the angle starts at pi.
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 16'h8000;
    end
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + 16'(ATAN_LUT[i]);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - 16'(ATAN_LUT[i]);
      end
    end
    return z;
  endfunction

  function automatic logic signed [31:0] sat32(input longint v);
    if (v > STEP_MAX) return 32'sh7FFF_FFFF;
    if (v < STEP_MIN) return 32'sh8000_0000;
    return 32'(v);
  endfunction

  function automatic estimate_t predict_estimate(input logic signed [ACC_W-1:0] acc_re,
                                                 input logic signed [ACC_W-1:0] acc_im);
    estimate_t          e;
    logic signed [15:0] angle;
    longint             slope;
    angle = cordic_angle(acc_re, acc_im);
    slope = (longint'(angle) * longint'(slope_gain)) >>> 16;
    e.phase_angle    = angle;
    e.frequency_step = sat32((longint'(angle) * longint'(freq_gain)) >>> 16);
    e.sampling_step  = sat32((longint'(angle) * longint'(samp_gain)) >>> 16);
    e.slope_clamped  = 1'b1;
    if (slope > SLOPE_MAX) begin
      e.slope_correction = 20'(-SLOPE_MAX);
    end else if (slope < -SLOPE_MAX) begin
      e.slope_correction = 20'(SLOPE_MAX);
    end else begin
      e.slope_correction = 20'(-slope);
      e.slope_clamped    = 1'b0;
    end
    return e;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : track
    longint    d0_re;
    longint    d0_im;
    longint    d1_re;
    longint    d1_im;
    estimate_t want;
    if (rst) begin
      corr_re    = '0;
      corr_im    = '0;
      freq_gain  = FREQ_GAIN_RESET;
      samp_gain  = SAMP_GAIN_RESET;
      slope_gain = SLOPE_GAIN_RESET;
      expected_estimates.delete();
    end else begin
      if (est_valid && est_ready) begin
        if (expected_estimates.size() == 0) begin
          errors++;
          $display("%0t: estimate expected none actual angle %0d", $time,
                   est_data.phase_angle);
        end else begin
          want = expected_estimates.pop_front();
          check_field("phase_angle", want.phase_angle, est_data.phase_angle);
          check_field("frequency_step", want.frequency_step, est_data.frequency_step);
          check_field("sampling_step", want.sampling_step, est_data.sampling_step);
          check_field("slope_correction", want.slope_correction, est_data.slope_correction);
          check_field("slope_clamped", want.slope_clamped, est_data.slope_clamped);
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_FREQ_GAIN:  freq_gain  = pwdata;
          REG_SAMP_GAIN:  samp_gain  = pwdata;
          REG_SLOPE_GAIN: slope_gain = pwdata;
          default: ;
        endcase
      end
      if (pilot_valid && pilot_ready) begin
        derotate(pilot_data.first_re, pilot_data.first_im, pilot_data.first_ref_re_neg,
                 pilot_data.first_ref_im_neg, d0_re, d0_im);
        derotate(pilot_data.second_re, pilot_data.second_im, pilot_data.second_ref_re_neg,
                 pilot_data.second_ref_im_neg, d1_re, d1_im);
        // second * conj(first), wrapping modulo 2^40
        corr_re = corr_re + ACC_W'(d1_re * d0_re + d1_im * d0_im);
        corr_im = corr_im + ACC_W'(d1_im * d0_re - d1_re * d0_im);
        if (pilot_data.last) begin
          expected_estimates.push_back(predict_estimate(corr_re, corr_im));
          corr_re = '0;
          corr_im = '0;
        end
      end
    end
    pending_estimates = expected_estimates.size();
  end

endmodule

>>> dv/tb_pilot_phase_offset_estimator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pilot_phase_offset_estimator_top: testbench of the pilot offset estimator
// Sends directed and random pilot runs under several gain settings, with
// bursty requests and a stalling estimate receiver; a checker compares results.
// ----------------------------------------------------------------------------
module tb_pilot_phase_offset_estimator_top;
  import ppoe_pkg::*;

  localparam int MAX_PILOTS    = 32;
  localparam int PHASES        = 8;
  localparam int PHASE_PILOTS  = 120;
  localparam int SETTLE_CYCLES = 40;
  localparam int IDLE_LIMIT    = 2000;
  localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = 4'hC;

  typedef enum int {
    STYLE_WIDE,
    STYLE_EXTREME,
    STYLE_SMALL,
    STYLE_ZERO,
    STYLE_ECHO,
    STYLE_WRAP
  } pilot_style_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                mismatches;
  int                pending;
  int                burst_left = 0;
  bit                gaps_on = 1'b1;
  int                idle_cycles = 0;

  ppoe_in_if  pilots ();
  ppoe_out_if estimate ();

  always #6 clk = ~clk;

  pilot_phase_offset_estimator_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .pilots   (pilots),
    .estimate (estimate),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  ppoe_estimate_checker u_checker (
    .clk               (clk),
    .rst               (rst),
    .pilot_valid       (pilots.valid),
    .pilot_ready       (pilots.ready),
    .pilot_data        (pilots.data),
    .est_valid         (estimate.valid),
    .est_ready         (estimate.ready),
    .est_data          (estimate.data),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .pready            (pready),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .mismatch_count    (mismatches),
    .pending_estimates (pending)
  );

  function automatic logic [ADDR_W-1:0] reg_addr(input reg_idx_t r);
    return ADDR_W'({r, 2'b00});
  endfunction

  function automatic pilot_t make_pilot(input logic [15:0] f_re, input logic [15:0] f_im,
                                        input logic f_rn, input logic f_in,
                                        input logic [15:0] s_re, input logic [15:0] s_im,
                                        input logic s_rn, input logic s_in, input logic last);
    pilot_t p;
    p.first_re          = f_re;
    p.first_im          = f_im;
    p.first_ref_re_neg  = f_rn;
    p.first_ref_im_neg  = f_in;
    p.second_re         = s_re;
    p.second_im         = s_im;
    p.second_ref_re_neg = s_rn;
    p.second_ref_im_neg = s_in;
    p.last              = last;
    return p;
  endfunction

  function automatic logic [15:0] sample_value(input pilot_style_t style);
    int v;
    case (style)
      STYLE_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       v = -32768;
          1:       v = 32767;
          2:       v = 0;
          3:       v = -1;
          default: v = 1;
        endcase
      end
      STYLE_SMALL: v = int'($urandom_range(0, 64)) - 32;
      STYLE_ZERO:  v = 0;
      STYLE_WRAP:  v = ($urandom_range(0, 1) != 0) ? -32768 : 32767;
      default:     v = int'($urandom);
    endcase
    return 16'(v);
  endfunction

  function automatic pilot_t random_pilot(input pilot_style_t style, input logic last);
    pilot_t p;
    p = make_pilot(sample_value(style), sample_value(style), 1'($urandom), 1'($urandom),
                   sample_value(style), sample_value(style), 1'($urandom), 1'($urandom),
                   last);
    // Echoed pairs repeat the first sample, so the correlation turns by quarter turns
    // only; with equal references it grows along the real axis until it wraps.
    if (style == STYLE_ECHO || style == STYLE_WRAP) begin
      p.second_re = p.first_re;
      p.second_im = p.first_im;
    end
    if (style == STYLE_WRAP) begin
      p.second_ref_re_neg = p.first_ref_re_neg;
      p.second_ref_im_neg = p.first_ref_im_neg;
    end
    return p;
  endfunction

  task automatic send_pilot(input pilot_t p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 9) : 0;
      if (gap != 0) begin
        pilots.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pilots.valid <= 1'b1;
    pilots.data  <= p;
    do @(posedge clk); while (!pilots.ready);
  endtask

  task automatic send_run(input int len, input pilot_style_t style);
    pilot_style_t s;
    for (int i = 0; i < len; i++) begin
      s = (style != STYLE_ZERO && $urandom_range(0, 7) == 0) ? STYLE_WIDE : style;
      send_pilot(random_pilot(s, i == len - 1));
    end
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every estimate has been taken, then lets the sequencer settle.
  task automatic wait_idle();
    pilots.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Estimate receiver: short and long stalls, with stretches of none at all.
  initial begin
    int  stall_left;
    int  pattern_cycles;
    bit  stalls_on;
    stall_left     = 0;
    pattern_cycles = 0;
    stalls_on      = 1'b0;
    estimate.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        estimate.ready <= 1'b0;
        stall_left--;
      end else begin
        estimate.ready <= 1'b1;
        if (stalls_on && $urandom_range(0, 3) == 0) begin
          stall_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 4);
        end
      end
      if (pattern_cycles == 0) begin
        pattern_cycles = $urandom_range(200, 800);
        stalls_on      = $urandom_range(0, 2) != 0;
      end else begin
        pattern_cycles--;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pilots.valid && pilots.ready) || (estimate.valid && estimate.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("pilot_phase_offset_estimator_top: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int                run_len;
    int                sent;
    int                pick;
    pilot_style_t      style;
    logic [DATA_W-1:0] f_gain;
    logic [DATA_W-1:0] s_gain;
    logic [DATA_W-1:0] sl_gain;
    rst          <= 1'b1;
    pilots.valid <= 1'b0;
    pilots.data  <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests under the reset gains.
    // Zero correlation gives a zero angle and zero corrections.
    send_pilot(make_pilot(16'd0, 16'd0, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b1));
    // A negative real correlation on the axis gives pi, which wraps negative.
    send_pilot(make_pilot(16'd1, 16'd1, 1'b0, 1'b0, -16'sd1, -16'sd1, 1'b0, 1'b0, 1'b1));
    // Quarter turns either way push the slope past its clamp.
    send_pilot(make_pilot(16'd1, 16'd1, 1'b0, 1'b0, -16'sd1, 16'd1, 1'b0, 1'b0, 1'b1));
    send_pilot(make_pilot(16'd1, 16'd1, 1'b0, 1'b0, 16'd1, -16'sd1, 1'b0, 1'b0, 1'b1));
    // Full-scale samples in one run.
    send_pilot(make_pilot(16'h8000, 16'h8000, 1'b1, 1'b1, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 1'b0));
    send_pilot(make_pilot(16'h7FFF, 16'h8000, 1'b0, 1'b1, 16'h8000, 16'h7FFF, 1'b1, 1'b0, 1'b0));
    send_pilot(make_pilot(16'h8000, 16'h7FFF, 1'b1, 1'b0, 16'h8000, 16'h8000, 1'b0, 1'b1, 1'b1));
    // A small angle keeps the slope inside its range.
    send_pilot(make_pilot(16'd1, 16'd1, 1'b0, 1'b0, 16'd499, 16'd501, 1'b0, 1'b0, 1'b1));
    // Every combination of reference signs within one run.
    for (int k = 0; k < 16; k++) begin
      send_pilot(make_pilot(16'($urandom), 16'($urandom), k[0], k[1],
                            16'($urandom), 16'($urandom), k[2], k[3], k == 15));
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          f_gain  = 32'h7FFF_FFFF;
          s_gain  = 32'h8000_0000;
          sl_gain = 32'h7FFF_FFFF;
        end
        1: begin
          f_gain  = 32'h8000_0000;
          s_gain  = 32'h7FFF_FFFF;
          sl_gain = 32'h8000_0000;
        end
        2: begin
          f_gain  = 32'h0000_0001;
          s_gain  = 32'hFFFF_FFFF;
          sl_gain = 32'h0000_0000;
        end
        3: begin
          f_gain  = 32'h0001_0000;
          s_gain  = 32'hFFFF_0000;
          sl_gain = 32'h0001_0000;
        end
        PHASES - 1: begin
          f_gain  = $urandom;
          s_gain  = $urandom;
          sl_gain = SLOPE_GAIN_RESET;
        end
        default: begin
          f_gain  = $urandom;
          s_gain  = $urandom;
          sl_gain = ($urandom_range(0, 1) != 0) ? $urandom
                  : 32'($urandom_range(0, 32'h40_0000)) - 32'h20_0000;
        end
      endcase
      apb_write(reg_addr(REG_FREQ_GAIN), f_gain);
      apb_write(reg_addr(REG_SAMP_GAIN), s_gain);
      apb_write(reg_addr(REG_SLOPE_GAIN), sl_gain);
      // A write past the register map must leave every gain alone.
      if (phase == 2) apb_write(UNMAPPED_ADDR, $urandom);
      gaps_on = (phase % 4) != 2;

      // Long runs of full-scale power carry the accumulators through their wrap.
      if (phase == 3 || phase == 5) send_run($urandom_range(130, 280), STYLE_WRAP);

      sent = 0;
      while (sent < PHASE_PILOTS) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          run_len = $urandom_range(1, 8);
        end else if (pick < 9) begin
          run_len = $urandom_range(9, MAX_PILOTS);
        end else begin
          run_len = $urandom_range(MAX_PILOTS + 1, 2 * MAX_PILOTS);
        end
        pick = $urandom_range(0, 15);
        if (pick == 0) begin
          style = STYLE_ZERO;
        end else if (pick < 4) begin
          style = STYLE_EXTREME;
        end else if (pick < 6) begin
          style = STYLE_SMALL;
        end else if (pick < 8) begin
          style = STYLE_ECHO;
        end else begin
          style = STYLE_WIDE;
        end
        send_run(run_len, style);
        sent += run_len;
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("pilot_phase_offset_estimator_top: match");
    end else begin
      $display("pilot_phase_offset_estimator_top: mismatch");
    end
    $finish;
  end

endmodule
